[hdl/mqttfh_pkg.sv]
// Package for the MQTT fixed header parser: item structs, parser state and codes.
// Used by mqttfh_step and mqtt_fixed_header_parser_top; depends on nothing else.
package mqttfh_pkg;

    localparam int unsigned LEN_W = 28;
    localparam int unsigned CNT_W = 3;

    localparam logic [CNT_W-1:0] MAX_VARINT_BYTES = 3'd4;
    localparam logic [LEN_W-1:0] BODY_COUNT_MAX   = 28'hFFF_FFFF;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_VARINT = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_VARINT  = 2'd1;
    localparam logic [1:0] ERR_LENGTH  = 2'd2;
    localparam logic [1:0] ERR_OVERRUN = 2'd3;

    localparam logic [3:0] TYPE_PUBLISH = 4'd3;
    localparam logic [3:0] TYPE_ID_LO   = 4'd4;
    localparam logic [3:0] TYPE_ID_HI   = 4'd11;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [3:0]       pkt_type;
        logic [3:0]       pkt_flags;
        logic [LEN_W-1:0] remaining_length;
        logic [2:0]       header_bytes;
        logic [15:0]      packet_id;
        logic             has_id;
        logic [1:0]       qos_level;
        logic             dup_flag;
        logic             retain_flag;
        logic [15:0]      topic_length;
        logic [LEN_W-1:0] payload_length;
        logic [1:0]       error_code;
    } t_out_item;

    typedef struct packed {
        logic [1:0]       phase;
        logic [7:0]       type_flags;
        logic [LEN_W-1:0] length_accum;
        logic [CNT_W-1:0] varint_count;
        logic [LEN_W-1:0] body_count;
        logic [15:0]      topic_len;
        logic [15:0]      id;
        logic             id_seen;
        logic [1:0]       err;
    } t_state;

endpackage

[hdl/mqttfh_step.sv]
// Per-byte update of the parser state and the packet summary on the last byte.
// Depends on mqttfh_pkg for the item structs, state struct and codes.
module mqttfh_step (
    input  mqttfh_pkg::t_state    i_state,
    input  mqttfh_pkg::t_in_item  i_item,
    output mqttfh_pkg::t_state    o_next,
    output mqttfh_pkg::t_out_item o_result
);

    mqttfh_pkg::t_state        n_state;
    logic [4:0]                shift_amt;
    logic [3:0]                cur_type;
    logic [1:0]                cur_qos;
    logic                      cur_has_id;
    logic [16:0]               id_pos;
    logic [3:0]                fin_type;
    logic [1:0]                fin_qos;
    logic [17:0]               fields_end;
    logic                      overrun;

    assign shift_amt  = 5'(i_state.varint_count) * 5'd7;
    assign cur_type   = i_state.type_flags[7:4];
    assign cur_qos    = i_state.type_flags[2:1];
    assign cur_has_id = (cur_type >= mqttfh_pkg::TYPE_ID_LO)
                        && (cur_type <= mqttfh_pkg::TYPE_ID_HI);
    assign id_pos     = {1'b0, i_state.topic_len} + 17'd2;

    always_comb begin
        n_state = i_state;
        case (i_state.phase)
            mqttfh_pkg::PH_FIRST: begin
                n_state            = '0;
                n_state.type_flags = i_item.rx_byte;
                n_state.phase      = mqttfh_pkg::PH_VARINT;
            end
            mqttfh_pkg::PH_VARINT: begin
                if (i_state.varint_count < mqttfh_pkg::MAX_VARINT_BYTES) begin
                    n_state.length_accum = i_state.length_accum
                        | (mqttfh_pkg::LEN_W'(i_item.rx_byte[6:0]) << shift_amt);
                    n_state.varint_count = i_state.varint_count + 3'd1;
                end
                if (!i_item.rx_byte[7]) begin
                    n_state.phase = mqttfh_pkg::PH_BODY;
                end else if (n_state.varint_count >= mqttfh_pkg::MAX_VARINT_BYTES) begin
                    n_state.err   = mqttfh_pkg::ERR_VARINT;
                    n_state.phase = mqttfh_pkg::PH_BODY;
                end
            end
            default: begin
                if (i_state.body_count == mqttfh_pkg::BODY_COUNT_MAX) begin
                    if (i_state.err == mqttfh_pkg::ERR_NONE) begin
                        n_state.err = mqttfh_pkg::ERR_LENGTH;
                    end
                end else begin
                    n_state.body_count = i_state.body_count + 28'd1;
                    if (cur_has_id) begin
                        if (i_state.body_count == 28'd0) begin
                            n_state.id = {i_item.rx_byte, 8'd0};
                        end else if (i_state.body_count == 28'd1) begin
                            n_state.id      = {i_state.id[15:8], i_item.rx_byte};
                            n_state.id_seen = 1'b1;
                        end
                    end else if (cur_type == mqttfh_pkg::TYPE_PUBLISH) begin
                        if (i_state.body_count == 28'd0) begin
                            n_state.topic_len = {i_item.rx_byte, 8'd0};
                        end else if (i_state.body_count == 28'd1) begin
                            n_state.topic_len = {i_state.topic_len[15:8], i_item.rx_byte};
                        end else if (cur_qos != 2'd0
                                     && i_state.body_count == 28'(id_pos)) begin
                            n_state.id = {i_item.rx_byte, 8'd0};
                        end else if (cur_qos != 2'd0
                                     && i_state.body_count == 28'(id_pos) + 28'd1) begin
                            n_state.id      = {i_state.id[15:8], i_item.rx_byte};
                            n_state.id_seen = 1'b1;
                        end
                    end
                end
            end
        endcase
    end

    assign fin_type   = n_state.type_flags[7:4];
    assign fin_qos    = n_state.type_flags[2:1];
    assign fields_end = {2'b0, n_state.topic_len} + 18'd2
                        + ((fin_qos != 2'd0) ? 18'd2 : 18'd0);

    always_comb begin
        o_result                  = '0;
        overrun                   = 1'b0;
        o_result.pkt_type         = fin_type;
        o_result.pkt_flags        = n_state.type_flags[3:0];
        o_result.remaining_length = n_state.length_accum;
        o_result.header_bytes     = n_state.varint_count;
        if ((fin_type >= mqttfh_pkg::TYPE_ID_LO) && (fin_type <= mqttfh_pkg::TYPE_ID_HI)) begin
            if (n_state.body_count >= 28'd2) begin
                o_result.packet_id = n_state.id;
                o_result.has_id    = 1'b1;
            end else begin
                overrun = 1'b1;
            end
        end else if (fin_type == mqttfh_pkg::TYPE_PUBLISH) begin
            o_result.retain_flag = n_state.type_flags[0];
            o_result.dup_flag    = n_state.type_flags[3];
            o_result.qos_level   = fin_qos;
            if (n_state.body_count < 28'd2) begin
                overrun = 1'b1;
            end else begin
                o_result.topic_length = n_state.topic_len;
                if (n_state.body_count < 28'(fields_end)) begin
                    overrun = 1'b1;
                end else begin
                    o_result.payload_length = n_state.body_count - 28'(fields_end);
                    if (fin_qos != 2'd0 && n_state.id_seen) begin
                        o_result.packet_id = n_state.id;
                        o_result.has_id    = 1'b1;
                    end
                end
            end
        end
        if (n_state.err != mqttfh_pkg::ERR_NONE) begin
            o_result.error_code = n_state.err;
        end else if (n_state.phase != mqttfh_pkg::PH_BODY
                     || n_state.body_count != n_state.length_accum) begin
            o_result.error_code = mqttfh_pkg::ERR_LENGTH;
        end else if (overrun) begin
            o_result.error_code = mqttfh_pkg::ERR_OVERRUN;
        end else begin
            o_result.error_code = mqttfh_pkg::ERR_NONE;
        end
    end

    always_comb begin
        o_next = n_state;
        if (i_item.last_byte) begin
            o_next       = '0;
            o_next.phase = mqttfh_pkg::PH_FIRST;
        end
    end

endmodule

[hdl/mqtt_fixed_header_parser_top.sv]
// Top level of the MQTT fixed header parser: input register, parser state, result register.
// Depends on mqttfh_pkg and mqttfh_step.
// Throughput is one byte per cycle unless a last byte waits on a stalled summary;
// a packet summary passes through the input register and the result register.
// Synchronous active-low reset empties both registers and returns to awaiting a first byte.
module mqtt_fixed_header_parser_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  mqttfh_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output mqttfh_pkg::t_out_item o_out_item
);

    logic                  r_in_valid;
    mqttfh_pkg::t_in_item  r_in;
    mqttfh_pkg::t_state    r_state;
    logic                  r_out_valid;
    mqttfh_pkg::t_out_item r_out;
    mqttfh_pkg::t_state    n_state;
    mqttfh_pkg::t_out_item n_out;
    logic                  proc;

    mqttfh_step u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .o_next   (n_state),
        .o_result (n_out)
    );

    assign proc        = r_in_valid && (!r_in.last_byte || !r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !proc;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The all-zero state is the awaiting-first-byte phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state       <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (proc) begin
                r_state <= n_state;
            end
            if (proc && r_in.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_item;
        end
        if (proc && r_in.last_byte) begin
            r_out <= n_out;
        end
    end

endmodule

[tb/tb_mqtt_fixed_header_parser_top.sv]
// Self-checking testbench for mqtt_fixed_header_parser_top: drives packet byte streams,
// predicts each summary with a parser state model or a literal; compares every result field.
// Depends on mqttfh_pkg and the parser RTL only.
module tb_mqtt_fixed_header_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mqttfh_pkg::*;

    localparam logic [LEN_W-1:0] BODY_SAT = 28'hFFF_FFFF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES = 1400;
    localparam int QUIET_TAIL = 150;

    typedef struct {
        t_in_item  item;
        bit        has_lit;
        t_out_item lit;
    } dir_row_t;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    t_in_item  i_in_item = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    t_state    hdr_st;
    t_out_item summary_q[$];
    dir_row_t  dir_tab[$];
    t_in_item  stream[$];
    logic [7:0] pbytes[$];
    int        fail_count = 0;
    int        idle_cycles = 0;
    int        out_hold = 0;
    bit        gaps_on = 1'b1;

    mqtt_fixed_header_parser_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_error($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    function automatic bit carries_id(input logic [3:0] ptype);
        return ptype >= TYPE_ID_LO && ptype <= TYPE_ID_HI;
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    // Parser state update for one accepted byte; done is set when a summary is due.
    task automatic parse_byte(input t_in_item it, output bit done, output t_out_item sum);
        logic [3:0]       ptype;
        logic [1:0]       qos;
        logic [LEN_W-1:0] pos;
        logic [LEN_W-1:0] chunk;
        logic [LEN_W-1:0] idpos;
        logic [LEN_W-1:0] fend;
        bit               overrun;
        done = 1'b0;
        sum = '0;
        overrun = 1'b0;
        ptype = hdr_st.type_flags[7:4];
        qos = hdr_st.type_flags[2:1];
        if (hdr_st.phase == PH_FIRST) begin
            hdr_st = '0;
            hdr_st.type_flags = it.rx_byte;
            hdr_st.phase = PH_VARINT;
            ptype = it.rx_byte[7:4];
            qos = it.rx_byte[2:1];
        end else if (hdr_st.phase == PH_VARINT) begin
            if (hdr_st.varint_count < MAX_VARINT_BYTES) begin
                chunk = {21'd0, it.rx_byte[6:0]};
                hdr_st.length_accum = hdr_st.length_accum | (chunk << (7 * hdr_st.varint_count));
                hdr_st.varint_count = hdr_st.varint_count + 3'd1;
            end
            if (!it.rx_byte[7]) begin
                hdr_st.phase = PH_BODY;
            end else if (hdr_st.varint_count >= MAX_VARINT_BYTES) begin
                hdr_st.err = ERR_VARINT;
                hdr_st.phase = PH_BODY;
            end
        end else begin
            pos = hdr_st.body_count;
            idpos = 28'd2 + {12'd0, hdr_st.topic_len};
            if (hdr_st.body_count >= BODY_SAT) begin
                if (hdr_st.err == ERR_NONE) hdr_st.err = ERR_LENGTH;
            end else begin
                hdr_st.body_count = hdr_st.body_count + 28'd1;
                if (carries_id(ptype)) begin
                    if (pos == 28'd0) begin
                        hdr_st.id = {it.rx_byte, 8'h00};
                    end else if (pos == 28'd1) begin
                        hdr_st.id[7:0] = it.rx_byte;
                        hdr_st.id_seen = 1'b1;
                    end
                end else if (ptype == TYPE_PUBLISH) begin
                    if (pos == 28'd0) begin
                        hdr_st.topic_len = {it.rx_byte, 8'h00};
                    end else if (pos == 28'd1) begin
                        hdr_st.topic_len[7:0] = it.rx_byte;
                    end else if (qos != 2'd0 && pos == idpos) begin
                        hdr_st.id = {it.rx_byte, 8'h00};
                    end else if (qos != 2'd0 && pos == idpos + 28'd1) begin
                        hdr_st.id[7:0] = it.rx_byte;
                        hdr_st.id_seen = 1'b1;
                    end
                end
            end
        end

        if (it.last_byte) begin
            sum.pkt_type = ptype;
            sum.pkt_flags = hdr_st.type_flags[3:0];
            sum.remaining_length = hdr_st.length_accum;
            sum.header_bytes = hdr_st.varint_count;
            if (carries_id(ptype)) begin
                if (hdr_st.body_count >= 28'd2) begin
                    sum.packet_id = hdr_st.id;
                    sum.has_id = 1'b1;
                end else begin
                    overrun = 1'b1;
                end
            end else if (ptype == TYPE_PUBLISH) begin
                sum.retain_flag = hdr_st.type_flags[0];
                sum.dup_flag = hdr_st.type_flags[3];
                sum.qos_level = qos;
                if (hdr_st.body_count < 28'd2) begin
                    overrun = 1'b1;
                end else begin
                    fend = 28'd2 + {12'd0, hdr_st.topic_len} + ((qos != 2'd0) ? 28'd2 : 28'd0);
                    sum.topic_length = hdr_st.topic_len;
                    if (hdr_st.body_count < fend) begin
                        overrun = 1'b1;
                    end else begin
                        sum.payload_length = hdr_st.body_count - fend;
                        if (qos != 2'd0 && hdr_st.id_seen) begin
                            sum.packet_id = hdr_st.id;
                            sum.has_id = 1'b1;
                        end
                    end
                end
            end
            if (hdr_st.err != ERR_NONE) begin
                sum.error_code = hdr_st.err;
            end else if (hdr_st.phase != PH_BODY || hdr_st.body_count != hdr_st.length_accum) begin
                sum.error_code = ERR_LENGTH;
            end else if (overrun) begin
                sum.error_code = ERR_OVERRUN;
            end else begin
                sum.error_code = ERR_NONE;
            end
            hdr_st = '0;
            hdr_st.phase = PH_FIRST;
            done = 1'b1;
        end
    endtask

    task automatic check_summary(input t_out_item got);
        t_out_item want;
        if (summary_q.size() == 0) begin
            report_error($sformatf("summary with no packet pending, type %0d", got.pkt_type));
        end else begin
            want = summary_q.pop_front();
            check_field("pkt_type", 32'(got.pkt_type), 32'(want.pkt_type));
            check_field("pkt_flags", 32'(got.pkt_flags), 32'(want.pkt_flags));
            check_field("remaining_length", 32'(got.remaining_length),
                        32'(want.remaining_length));
            check_field("header_bytes", 32'(got.header_bytes), 32'(want.header_bytes));
            check_field("packet_id", 32'(got.packet_id), 32'(want.packet_id));
            check_field("has_id", 32'(got.has_id), 32'(want.has_id));
            check_field("qos_level", 32'(got.qos_level), 32'(want.qos_level));
            check_field("dup_flag", 32'(got.dup_flag), 32'(want.dup_flag));
            check_field("retain_flag", 32'(got.retain_flag), 32'(want.retain_flag));
            check_field("topic_length", 32'(got.topic_length), 32'(want.topic_length));
            check_field("payload_length", 32'(got.payload_length),
                        32'(want.payload_length));
            check_field("error_code", 32'(got.error_code), 32'(want.error_code));
        end
    endtask

    task automatic send_item(input t_in_item it, input bit has_lit, input t_out_item lit);
        bit        done;
        t_out_item sum;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        parse_byte(it, done, sum);
        if (done) summary_q.push_back(has_lit ? lit : sum);
    endtask

    function automatic t_out_item mk_summary(input logic [3:0] ptype, input logic [3:0] flags,
                                             input logic [LEN_W-1:0] rl,
                                             input logic [2:0] hb, input logic [15:0] pid,
                                             input logic hid, input logic [1:0] err);
        t_out_item s;
        s = '0;
        s.pkt_type = ptype;
        s.pkt_flags = flags;
        s.remaining_length = rl;
        s.header_bytes = hb;
        s.packet_id = pid;
        s.has_id = hid;
        s.error_code = err;
        return s;
    endfunction

    task automatic add_row(input logic [7:0] b, input logic last, input bit has_lit,
                           input t_out_item lit);
        dir_row_t row;
        row.item.rx_byte = b;
        row.item.last_byte = last;
        row.has_lit = has_lit;
        row.lit = lit;
        dir_tab.push_back(row);
    endtask

    function automatic int unsigned varint_len(input int unsigned v);
        if (v < 128) return 1;
        if (v < 16384) return 2;
        if (v < 2097152) return 3;
        return 4;
    endfunction

    function automatic int unsigned body_len();
        if ($urandom_range(0, 99) < 97) return $urandom_range(0, 10);
        return $urandom_range(120, 140);
    endfunction

    task automatic put_varint(input int unsigned value, input int unsigned nbytes);
        logic [31:0] grp;
        for (int unsigned k = 0; k < nbytes; k++) begin
            grp = value >> (7 * k);
            pbytes.push_back({k != nbytes - 1, grp[6:0]});
        end
    endtask

    // One packet: mostly well formed, the rest with bad lengths, truncation,
    // overrunning fields, an over-long varint, or plain noise.
    task automatic make_packet();
        int unsigned sel;
        int unsigned kind;
        int unsigned tlen;
        int unsigned plen;
        int unsigned rl;
        int unsigned nb;
        int unsigned cut;
        logic [31:0] r;
        logic [3:0]  ptype;
        logic [3:0]  flags;
        logic [15:0] tfield;
        logic [7:0]  body[$];
        t_in_item    it;
        bit          ovr;
        pbytes.delete();
        body.delete();
        sel = $urandom_range(0, 99);
        r = $urandom;
        flags = r[3:0];
        ovr = sel >= 70 && sel < 78;
        if (sel >= 85) begin
            repeat ($urandom_range(1, 8)) pbytes.push_back(rand_byte());
        end else if (sel >= 78) begin
            pbytes.push_back(rand_byte());
            repeat (4) pbytes.push_back(rand_byte() | 8'h80);
            repeat ($urandom_range(0, 3)) pbytes.push_back(rand_byte());
        end else begin
            kind = ovr ? $urandom_range(0, 1) : $urandom_range(0, 2);
            if (kind == 0) begin
                ptype = TYPE_PUBLISH;
                tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
                plen = body_len();
                tfield = 16'(tlen);
                if (ovr) tfield = 16'(tlen + plen + 1 + $urandom_range(0, 3));
                body.push_back(tfield[15:8]);
                body.push_back(tfield[7:0]);
                repeat (tlen) body.push_back(rand_byte());
                if (flags[2:1] != 2'd0) repeat (2) body.push_back(rand_byte());
                repeat (plen) body.push_back(rand_byte());
            end else if (kind == 1) begin
                r = $urandom_range(4, 11);
                ptype = r[3:0];
                if (ovr) begin
                    repeat ($urandom_range(0, 1)) body.push_back(rand_byte());
                end else begin
                    repeat (2 + body_len() / 3) body.push_back(rand_byte());
                end
            end else begin
                r = $urandom;
                ptype = r[3:0];
                repeat (body_len()) body.push_back(rand_byte());
            end
            rl = body.size();
            if (sel >= 55 && sel < 62) begin
                if ($urandom_range(0, 3) == 0) rl = $urandom_range(0, 32'h0FFF_FFFF);
                else if (rl > 0 && $urandom_range(0, 1) == 0) rl = rl - 1;
                else rl = rl + $urandom_range(1, 3);
            end
            nb = varint_len(rl);
            if ($urandom_range(0, 3) == 0) nb = $urandom_range(nb, 4);
            pbytes.push_back({ptype, flags});
            put_varint(rl, nb);
            foreach (body[i]) pbytes.push_back(body[i]);
        end
        cut = pbytes.size() - 1;
        if (sel >= 62 && sel < 70) cut = $urandom_range(0, pbytes.size() - 1);
        for (int unsigned i = 0; i <= cut; i++) begin
            it.rx_byte = pbytes[i];
            it.last_byte = (i == cut);
            stream.push_back(it);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_summary(o_out_item);
        if (out_hold != 0) begin
            out_hold--;
            i_out_stall <= 1'b1;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            out_hold = $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_mqtt_fixed_header_parser_top: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned drain_at;
        hdr_st = '0;
        hdr_st.phase = PH_FIRST;
        drain_at = 0;

        add_row(8'hF0, 1'b1, 1'b1, mk_summary(4'hF, 4'h0, 28'd0, 3'd0, 16'd0, 1'b0, ERR_LENGTH));
        add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(8'h80, 1'b0, 1'b0, '0);
        add_row(8'h80, 1'b0, 1'b0, '0);
        add_row(8'h80, 1'b0, 1'b0, '0);
        add_row(8'h80, 1'b1, 1'b1, mk_summary(4'hF, 4'hF, 28'd0, 3'd4, 16'd0, 1'b0, ERR_VARINT));
        add_row(8'h20, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(8'h7F, 1'b1, 1'b1,
                mk_summary(4'h2, 4'h0, 28'hFFF_FFFF, 3'd4, 16'd0, 1'b0, ERR_LENGTH));
        add_row(8'h40, 1'b0, 1'b0, '0);
        add_row(8'h02, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b1, 1'b1, mk_summary(4'h4, 4'h0, 28'd2, 3'd1, 16'hFFFF, 1'b1, ERR_NONE));
        add_row(8'hB0, 1'b0, 1'b0, '0);
        add_row(8'h01, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b1, 1'b1, mk_summary(4'hB, 4'h0, 28'd1, 3'd1, 16'd0, 1'b0, ERR_OVERRUN));
        add_row(8'h3B, 1'b0, 1'b0, '0);
        add_row(8'h06, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'h01, 1'b0, 1'b0, '0);
        add_row(8'h61, 1'b0, 1'b0, '0);
        add_row(8'h12, 1'b0, 1'b0, '0);
        add_row(8'h34, 1'b0, 1'b0, '0);
        add_row(8'h55, 1'b1, 1'b0, '0);

        while (stream.size() < RANDOM_BYTES) begin
            make_packet();
            if (drain_at == 0 && stream.size() >= RANDOM_BYTES / 2) drain_at = stream.size();
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].has_lit, dir_tab[i].lit);

        foreach (stream[i]) begin
            gaps_on = (i < stream.size() - QUIET_TAIL) && ((i / 200) % 3 != 2);
            if (i == drain_at) begin
                i_in_valid <= 1'b0;
                while (summary_q.size() != 0) @(posedge i_clk);
            end
            send_item(stream[i], 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (summary_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_mqtt_fixed_header_parser_top: PASS");
        end else begin
            $display("tb_mqtt_fixed_header_parser_top: FAIL");
        end
        $finish;
    end

endmodule
